>>> hdl/tqg_pkg.sv
`default_nettype none

package tqg_pkg;

    // Width of one symbol in the q-gram window.
    localparam int unsigned SYM_W = 5;

    localparam logic [SYM_W-1:0] SEP_CODE   = 5'd31;
    localparam logic [SYM_W-1:0] THREE_CODE = 5'd30;
    localparam logic [SYM_W-1:0] NULL_CODE  = 5'd0;

    typedef logic [SYM_W-1:0] sym_t;

    // Look-alike letters for the digits 0 to 9 (3 gets its own code).
    localparam sym_t DIGIT_SYM [10] = '{
        5'd15, 5'd9, 5'd26, THREE_CODE, 5'd1, 5'd19, 5'd7, 5'd20, 5'd2, 5'd17
    };

    // Maps a raw byte to its symbol. The letters sit at the same low five
    // bits in both cases, so A and a both give 1.
    function automatic sym_t map_byte(input logic [7:0] b);
        sym_t s;
        case (b) inside
            [8'h41:8'h5A], [8'h61:8'h7A]: s = b[SYM_W-1:0];
            [8'h30:8'h39]:                s = DIGIT_SYM[b[3:0]];
            8'h20, 8'h2D, 8'h5F:          s = SEP_CODE;
            default:                      s = NULL_CODE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tqg_if.sv
`default_nettype none

// Byte channel into the extractor.
interface tqg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_string;

    modport source (output valid, output text_byte, output end_of_string, input ready);
    modport sink   (input valid, input text_byte, input end_of_string, output ready);
endinterface

// Q-gram channel out of the extractor.
interface tqg_out_if #(
    parameter int unsigned WIN_W = 25
);
    logic             valid;
    logic             ready;
    logic [WIN_W-1:0] qgram_value;
    logic             window_full;

    modport source (output valid, output qgram_value, output window_full, input ready);
    modport sink   (input valid, input qgram_value, input window_full, output ready);
endinterface

`default_nettype wire

>>> hdl/text_qgram_extractor_top.sv
`default_nettype none

// Channel     Modport  Words carried
// ----------  -------  ------------------------------------------------------
// text_in     sink     text_byte[7:0], end_of_string
// qgram_out   source   qgram_value[5*GRAM_LENGTH-1:0], window_full
//
// One byte word is taken every cycle while text_in.ready is high. Its q-gram,
// if any, is registered in the main output register, or in the skid register
// if the main one is stalled. The window state is updated in the same cycle
// that the byte is taken. Reset clears the window, the symbol count and the
// buffer, and sets the separator flag. A stalled qgram_out is absorbed by a
// two-word output buffer; text_in only drops ready when both words are held.
module text_qgram_extractor_top #(
    parameter int unsigned GRAM_LENGTH = 5
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tqg_in_if.sink    text_in,
    tqg_out_if.source qgram_out
);
    import tqg_pkg::*;

    // The window holds GRAM_LENGTH symbols, the oldest in the top bits.
    localparam int unsigned WIN_W = SYM_W * GRAM_LENGTH;
    // The count saturates at GRAM_LENGTH, so it needs room for that value.
    localparam int unsigned CNT_W = $clog2(GRAM_LENGTH + 1);
    localparam logic [CNT_W-1:0] GRAM_CNT = CNT_W'(GRAM_LENGTH);

    logic [WIN_W-1:0] window_reg, window_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic             after_sep_reg, after_sep_next;

    sym_t             sym;
    logic             special;
    logic             letter;
    logic             keep;
    logic             accept;
    logic [WIN_W-1:0] win_kept;
    logic [CNT_W-1:0] seen_kept;
    logic             gram_full;
    logic             gram_short;
    logic             push_valid;
    logic             push_ready;

    assign accept = text_in.valid && text_in.ready;

    // Symbol classification. Separators and the digit three both arm the
    // separator flag; a kept byte is any letter or look-alike digit, or
    // anything at all when the separator flag is clear.
    assign sym     = map_byte(text_in.text_byte);
    assign special = (sym == SEP_CODE) || (sym == THREE_CODE);
    assign letter  = (sym != NULL_CODE) && !special;
    assign keep    = letter || !after_sep_reg;

    // A dropped byte leaves the window and count untouched.
    always_comb
    begin
        win_kept  = window_reg;
        seen_kept = seen_reg;
        if (keep)
        begin
            win_kept = {window_reg[WIN_W-SYM_W-1:0], sym};
            if (seen_reg < GRAM_CNT)
            begin
                seen_kept = seen_reg + CNT_W'(1);
            end
        end
    end

    // A full gram for every kept symbol once the window is filled; at the
    // end of a string, a short nonzero window is flushed once.
    assign gram_full  = keep && (seen_kept == GRAM_CNT);
    assign gram_short = text_in.end_of_string && !gram_full &&
                        (seen_kept < GRAM_CNT) && (win_kept != '0);
    assign push_valid = accept && (gram_full || gram_short);

    always_comb
    begin
        window_next    = window_reg;
        seen_next      = seen_reg;
        after_sep_next = after_sep_reg;
        if (accept)
        begin
            if (text_in.end_of_string)
            begin
                window_next    = '0;
                seen_next      = '0;
                after_sep_next = 1'b1;
            end
            else
            begin
                window_next    = win_kept;
                seen_next      = seen_kept;
                after_sep_next = special;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            seen_reg      <= '0;
            after_sep_reg <= 1'b1;
        end
        else
        begin
            window_reg    <= window_next;
            seen_reg      <= seen_next;
            after_sep_reg <= after_sep_next;
        end
    end

    assign text_in.ready = push_ready;

    tqg_skid #(
        .WIN_W (WIN_W)
    ) u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_value (win_kept),
        .push_full  (gram_full),
        .push_ready (push_ready),
        .qgram_out  (qgram_out)
    );

    // The symbol count never passes the gram length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= GRAM_CNT)
        else $error("symbol count beyond gram length");

    // The last byte of a string leaves the state at its reset value.
    a_string_reset: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_in.end_of_string |=>
            (window_reg == '0) && (seen_reg == '0) && after_sep_reg)
        else $error("state not cleared after end of string");

    // A short gram is never empty and never comes from a full window.
    a_short_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !gram_full |-> (win_kept != '0) && (seen_kept < GRAM_CNT))
        else $error("bad short gram");

    // A full gram only comes from a kept byte with a filled window.
    a_full_kept: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && gram_full |-> keep && (seen_kept == GRAM_CNT))
        else $error("full gram without a filled window");

endmodule

`default_nettype wire

>>> hdl/tqg_skid.sv
`default_nettype none

// Two-entry output buffer: a main register that drives the channel and a
// skid register that catches a word produced while the main one is stalled.
module tqg_skid #(
    parameter int unsigned WIN_W = 25
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire logic [WIN_W-1:0] push_value,
    input  wire logic             push_full,
    output logic                  push_ready,
    tqg_out_if.source             qgram_out
);
    localparam int unsigned DATA_W = WIN_W + 1;

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] main_data_reg, main_data_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;
    logic [DATA_W-1:0] push_data;
    logic              pop;

    assign push_data  = {push_value, push_full};
    assign pop        = main_valid_reg && qgram_out.ready;
    assign push_ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push_valid;
                main_data_next  = push_data;
            end
        end
        else if (push_valid)
        begin
            if (main_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
            else
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign qgram_out.valid       = main_valid_reg;
    assign qgram_out.qgram_value = main_data_reg[DATA_W-1:1];
    assign qgram_out.window_full = main_data_reg[0];

    // The skid register only fills behind a stalled main register.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word held with no main word");

    // A stalled word does not change until it is taken.
    a_main_holds: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg && !qgram_out.ready |=> main_valid_reg && $stable(main_data_reg))
        else $error("stalled output word changed");

    // A push never arrives while the buffer is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !skid_valid_reg)
        else $error("push into a full output buffer");

endmodule

`default_nettype wire
